// File: rtl/del_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// double-ended list engine. No dependencies.
`timescale 1ns / 1ps

package del_pkg;

    // Slot arithmetic wraps by truncation, so CAPACITY must be a power of two.
    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int FIND_W = 4;
    localparam int OCNT_W = 5;

    // Stream packing: byte-padded tdata, tuser carries the kind / status code.
    localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + FIND_W + OCNT_W + 7) / 8) * 8;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TUSER_W = STAT_W;

    localparam logic [CNT_W-1:0]         CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic signed [DATA_W-1:0] DATA_FAIL = -32'sd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_POP_BACK   = 3'd1,
        KIND_PUSH_FRONT = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_READ       = 3'd4,
        KIND_FIND       = 3'd5,
        KIND_REVERSE    = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // run the operation once
        logic scan;   // one search step
        logic emit;   // move the result into the output register
    } del_cmd_t;

    typedef struct packed {
        logic is_find;
        logic scan_done;
    } del_stat_t;

endpackage

// File: rtl/del_dpath.sv
// Datapath: entry memory, end pointers, count, orientation flag, search
// scan and the output register. Depends on del_pkg.
`timescale 1ns / 1ps

module del_dpath
    import del_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  del_cmd_t                 cmd,
    output del_stat_t                stat,
    input  kind_t                    in_kind,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [POS_W-1:0]         in_position,
    output logic signed [DATA_W-1:0] data_out,
    output logic [FIND_W-1:0]        found_index,
    output logic [OCNT_W-1:0]        count,
    output status_t                  status
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    kind_t                    op_kind_reg;
    logic signed [DATA_W-1:0] op_value_reg;
    logic [POS_W-1:0]         op_pos_reg;

    logic [SLOT_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;

    logic signed [DATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [POS_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;

    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic [FIND_W-1:0]        res_found_reg, res_found_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_mem_reg, res_mem_next;

    logic signed [DATA_W-1:0] out_data_reg;
    logic [FIND_W-1:0]        out_found_reg;
    logic [OCNT_W-1:0]        out_count_reg;
    status_t                  out_status_reg;

    logic              at_bottom, from_bottom, full, empty, match, scan_more;
    logic [SLOT_W-1:0] slot_top, slot_last, rd_lslot;
    logic [CNT_W-1:0]  rd_idx;
    logic              wr_en, rd_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;

    assign at_bottom   = (op_kind_reg == KIND_PUSH_FRONT) != rev_reg;
    assign from_bottom = (op_kind_reg == KIND_POP_FRONT) != rev_reg;
    assign full        = count_reg >= CAP_CNT;
    assign empty       = count_reg == '0;
    assign slot_top    = front_reg + count_reg[SLOT_W-1:0];
    assign slot_last   = slot_top - SLOT_W'(1);

    // logical index -> physical slot
    assign rd_idx   = cmd.scan ? scan_idx_reg : CNT_W'(op_pos_reg);
    assign rd_lslot = rev_reg ? front_reg + SLOT_W'(count_reg - CNT_W'(1) - rd_idx)
                              : front_reg + SLOT_W'(rd_idx);

    assign match     = cmp_valid_reg && (rd_data_reg == op_value_reg);
    assign scan_more = scan_idx_reg < count_reg;

    assign stat.is_find   = op_kind_reg == KIND_FIND;
    assign stat.scan_done = match || !scan_more;

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_mem_next    = res_mem_reg;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        rd_en           = 1'b0;
        rd_addr         = front_reg;

        if (cmd.exec)
        begin
            res_data_next   = '0;
            res_found_next  = '0;
            res_status_next = STAT_OK;
            res_mem_next    = 1'b0;
            unique case (op_kind_reg)
                KIND_PUSH_BACK, KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (at_bottom)
                        begin
                            front_next = front_reg - SLOT_W'(1);
                            wr_addr    = front_reg - SLOT_W'(1);
                        end
                        else
                        begin
                            wr_addr = slot_top;
                        end
                    end
                end
                KIND_POP_BACK, KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        res_data_next   = DATA_FAIL;
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        res_mem_next = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                        if (from_bottom)
                        begin
                            rd_addr    = front_reg;
                            front_next = front_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            rd_addr = slot_last;
                        end
                    end
                end
                KIND_READ:
                begin
                    if (CNT_W'(op_pos_reg) < count_reg)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = rd_lslot;
                        res_mem_next = 1'b1;
                    end
                    else
                    begin
                        res_data_next   = DATA_FAIL;
                        res_status_next = STAT_EMPTY;
                    end
                end
                KIND_FIND:
                begin
                    scan_idx_next  = CNT_W'(op_pos_reg);
                    cmp_valid_next = 1'b0;
                end
                KIND_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                end
            endcase
        end

        // one read issued per cycle, compare runs one entry behind
        if (cmd.scan)
        begin
            priority if (match)
            begin
                res_found_next  = cmp_idx_reg;
                res_status_next = STAT_OK;
                cmp_valid_next  = 1'b0;
            end
            else if (scan_more)
            begin
                rd_en          = 1'b1;
                rd_addr        = rd_lslot;
                cmp_idx_next   = scan_idx_reg[POS_W-1:0];
                cmp_valid_next = 1'b1;
                scan_idx_next  = scan_idx_reg + CNT_W'(1);
            end
            else
            begin
                res_found_next  = '0;
                res_status_next = STAT_NOT_FOUND;
                cmp_valid_next  = 1'b0;
            end
        end
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= op_value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            res_mem_reg   <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            cmp_valid_reg <= cmp_valid_next;
            res_mem_reg   <= res_mem_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_kind_reg  <= in_kind;
            op_value_reg <= in_value;
            op_pos_reg   <= in_position;
        end
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (cmd.emit)
        begin
            out_data_reg   <= res_mem_reg ? rd_data_reg : res_data_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= OCNT_W'(count_reg);
            out_status_reg <= res_status_reg;
        end
    end

    assign data_out    = out_data_reg;
    assign found_index = out_found_reg;
    assign count       = out_count_reg;
    assign status      = out_status_reg;

endmodule

// File: rtl/del_ctrl.sv
// Controller: sequences accept, execute, search scan and result hand-off.
// Depends on del_pkg.
`timescale 1ns / 1ps

module del_ctrl
    import del_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  del_stat_t stat,
    output del_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && in_valid;
        cmd.exec = state_reg == ST_EXEC;
        cmd.scan = state_reg == ST_SCAN;
        cmd.emit = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = stat.is_find ? ST_SCAN : ST_EMIT;
            ST_SCAN: if (stat.scan_done) state_next = ST_EMIT;
            ST_EMIT: if (cmd.emit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/double_ended_list_engine.sv
// Top level of the double-ended list engine: stream ports, controller and
// datapath. Depends on del_pkg, del_ctrl, del_dpath.
`timescale 1ns / 1ps

// Bounded double-ended list of CAPACITY signed 32-bit words.
// Input channel (s_*): one beat per operation. s_tuser carries the operation
//   kind; s_tdata carries the word to push or search for and the position.
// Output channel (m_*): exactly one result beat per input beat, in order.
//   m_tuser carries the status code; m_tdata carries the popped/read word,
//   the search hit index and the entry count after the operation.
// Sequence: push, pop, read, reverse and the unused kind pass from accept to
//   m_tvalid through accept, execute with at most one memory access, load output.
//   A search scans one stored entry per cycle through the single memory read
//   port, compare one entry behind the read, from position up to the count.
//   s_tready returns high the cycle after the result is loaded, so one item
//   is in work at a time.
// The result sits in an output register: while the receiver stalls the
//   engine still accepts and executes the next beat, and holds only at the
//   point of loading its own result.
// Reset: list empty, orientation normal, no result pending. The entry store
//   itself is not cleared; only written slots are ever read.
// Reverse flips an orientation flag; no data moves.

module double_ended_list_engine
    import del_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], position[35:32], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // kind[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // data_out[31:0], found_index[35:32],
                                            // count[40:36], zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // status[1:0]
);

    del_cmd_t  cmd;
    del_stat_t stat;

    logic signed [DATA_W-1:0] data_out;
    logic [FIND_W-1:0]        found_index;
    logic [OCNT_W-1:0]        count;
    status_t                  status;

    del_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    del_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (kind_t'(s_tuser)),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_position (s_tdata[DATA_W+POS_W-1:DATA_W]),
        .data_out    (data_out),
        .found_index (found_index),
        .count       (count),
        .status      (status)
    );

    assign m_tdata = M_TDATA_W'({count, found_index, data_out});
    assign m_tuser = status;

endmodule

// File: rtl/del_checker.sv
// Port-level checker for the double-ended list engine, bound to the top
// level. Depends on del_pkg and double_ended_list_engine.
`timescale 1ns / 1ps

module del_checker
    import del_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // count never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DATA_W+FIND_W+OCNT_W-1:DATA_W+FIND_W] <= OCNT_W'(CAPACITY)))
        else $error("count above capacity");

    // refused push only when the list is full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_FULL))
        |-> (m_tdata[DATA_W+FIND_W+OCNT_W-1:DATA_W+FIND_W] == OCNT_W'(CAPACITY)))
        else $error("full status with list not full");

    // failed pop or read returns all ones
    a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_EMPTY)) |-> (m_tdata[DATA_W-1:0] == DATA_FAIL))
        else $error("failed pop/read without -1 data");

    // a missed search reports zero data and zero index
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_NOT_FOUND))
        |-> ((m_tdata[DATA_W-1:0] == '0) && (m_tdata[DATA_W+FIND_W-1:DATA_W] == '0)))
        else $error("missed search with nonzero fields");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind double_ended_list_engine del_checker u_del_checker (.*);
